// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the rtl modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define OCR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define OCR_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ocr_pkg.sv =====
// ----------------------------------------------------------------------------
// ocr_pkg
// types, constants and helpers of the ospf receive checker
// ----------------------------------------------------------------------------
package ocr_pkg;

  localparam int LEN_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int MAX_FRAME_BYTES_DEF = 2048;

  // frame byte offsets
  localparam logic [LEN_W-1:0] POS_SRC_FIRST   = LEN_W'(26);
  localparam logic [LEN_W-1:0] POS_SRC_LAST    = LEN_W'(29);
  localparam logic [LEN_W-1:0] OSPF_START      = LEN_W'(34);
  localparam logic [LEN_W-1:0] POS_TYPE        = LEN_W'(35);
  localparam logic [LEN_W-1:0] POS_RID_FIRST   = LEN_W'(38);
  localparam logic [LEN_W-1:0] POS_RID_LAST    = LEN_W'(41);
  localparam logic [LEN_W-1:0] POS_AREA_FIRST  = LEN_W'(42);
  localparam logic [LEN_W-1:0] POS_AREA_LAST   = LEN_W'(45);
  localparam logic [LEN_W-1:0] POS_AUTYPE_HI   = LEN_W'(48);
  localparam logic [LEN_W-1:0] POS_AUTYPE_LO   = LEN_W'(49);
  localparam logic [LEN_W-1:0] AUTH_DATA_FIRST = LEN_W'(50);
  localparam logic [LEN_W-1:0] AUTH_DATA_LAST  = LEN_W'(57);
  localparam logic [LEN_W-1:0] BODY_START      = LEN_W'(58);
  localparam logic [LEN_W-1:0] POS_BODY_A_LAST = LEN_W'(61);
  localparam logic [LEN_W-1:0] POS_BODY_B_FIRST = LEN_W'(62);
  localparam logic [LEN_W-1:0] HELLO_END       = LEN_W'(66);
  localparam logic [LEN_W-1:0] POS_BODY_B_LAST = LEN_W'(65);

  localparam logic [7:0]  OSPF_VERSION = 8'd2;
  localparam logic [7:0]  PKT_HELLO    = 8'd1;
  localparam logic [7:0]  PKT_LSU      = 8'd4;
  localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
  localparam int          AD_BYTES     = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_ID             = 2'd0,
    CFG_PORT_NETMASK        = 2'd1,
    CFG_PORT_HELLO_INTERVAL = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    VERDICT_OK        = 4'd0,
    VERDICT_SHORT     = 4'd1,
    VERDICT_VERSION   = 4'd2,
    VERDICT_CHECKSUM  = 4'd3,
    VERDICT_AREA      = 4'd4,
    VERDICT_AUTH      = 4'd5,
    VERDICT_NETMASK   = 4'd6,
    VERDICT_INTERVAL  = 4'd7,
    VERDICT_LSU_SHORT = 4'd8
  } verdict_t;

  // summary of one frame, handed from the byte front end to the judge
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [15:0]      sum;
    logic [7:0]       held;
    logic             ver_ok;
    logic             area_ok;
    logic             auth_ok;
    logic             mask_ok;
    logic             intvl_ok;
    logic [7:0]       pkt_type;
    logic [31:0]      router_id;
    logic [31:0]      source_ip;
    logic [15:0]      lsu_seq;
    logic [31:0]      advert_count;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ones' complement 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/core/ocr_front.sv =====
// ----------------------------------------------------------------------------
// ocr_front
// byte front end: field capture, running checksum, per-frame classification
// ----------------------------------------------------------------------------
module ocr_front #(
  parameter int MAX_FRAME_BYTES = ocr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic [31:0]         area_id,
  input  logic [31:0]         port_netmask,
  input  logic [15:0]         port_hello_interval,
  input  ocr_pkg::q_stat_t    q_stat,
  output logic                push,
  output ocr_pkg::frame_rec_t push_rec
);

  `include "assert_macros.svh"

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt, len_upd;
  logic [15:0]      sum_r, sum_nxt, sum_upd;
  logic [7:0]       held_r, held_nxt, held_upd;
  logic [7:0]       ver_r, ver_nxt, ver_upd;
  logic [7:0]       type_r, type_nxt, type_upd;
  logic [7:0]       auth_r, auth_nxt, auth_upd;
  logic [31:0]      rid_r, rid_nxt, rid_upd;
  logic [31:0]      area_r, area_nxt, area_upd;
  logic [31:0]      src_r, src_nxt, src_upd;
  logic [31:0]      body_a_r, body_a_nxt, body_a_upd;
  logic [31:0]      body_b_r, body_b_nxt, body_b_upd;
  logic [ocr_pkg::LEN_W-1:0] pos_x;
  logic             take;
  logic             fire;
  logic [7:0]       sum_byte;

  // a frame end needs a queue slot, plain bytes always go in
  assign in_ready = !q_stat.full || !in_last_byte;
  assign fire     = in_valid && in_ready;
  assign push     = fire && in_last_byte;

  always_comb begin
    pos_x      = ocr_pkg::LEN_W'(pos_r);
    take       = pos_r < POS_W'(MAX_FRAME_BYTES);
    sum_upd    = sum_r;
    held_upd   = held_r;
    ver_upd    = ver_r;
    type_upd   = type_r;
    auth_upd   = auth_r;
    rid_upd    = rid_r;
    area_upd   = area_r;
    src_upd    = src_r;
    body_a_upd = body_a_r;
    body_b_upd = body_b_r;
    sum_byte   = in_data_byte;
    if (take) begin
      if (pos_x >= ocr_pkg::POS_SRC_FIRST && pos_x <= ocr_pkg::POS_SRC_LAST) begin
        src_upd = {src_r[23:0], in_data_byte};
      end
      if (pos_x == ocr_pkg::OSPF_START) begin
        ver_upd = in_data_byte;
      end
      if (pos_x == ocr_pkg::POS_TYPE) begin
        type_upd = in_data_byte;
      end
      if (pos_x >= ocr_pkg::POS_RID_FIRST && pos_x <= ocr_pkg::POS_RID_LAST) begin
        rid_upd = {rid_r[23:0], in_data_byte};
      end
      if (pos_x >= ocr_pkg::POS_AREA_FIRST && pos_x <= ocr_pkg::POS_AREA_LAST) begin
        area_upd = {area_r[23:0], in_data_byte};
      end
      if (pos_x == ocr_pkg::POS_AUTYPE_HI || pos_x == ocr_pkg::POS_AUTYPE_LO) begin
        auth_upd = auth_r | in_data_byte;
      end
      if (pos_x >= ocr_pkg::BODY_START && pos_x <= ocr_pkg::POS_BODY_A_LAST) begin
        body_a_upd = {body_a_r[23:0], in_data_byte};
      end
      if (pos_x >= ocr_pkg::POS_BODY_B_FIRST && pos_x <= ocr_pkg::POS_BODY_B_LAST) begin
        body_b_upd = {body_b_r[23:0], in_data_byte};
      end
      if (pos_x >= ocr_pkg::OSPF_START) begin
        // auth data counts as zero in the checksum
        if (pos_x >= ocr_pkg::AUTH_DATA_FIRST && pos_x <= ocr_pkg::AUTH_DATA_LAST) begin
          sum_byte = 8'h00;
        end
        // ospf starts on an even offset, so even positions are high bytes
        if (!pos_x[0]) begin
          held_upd = sum_byte;
        end else begin
          sum_upd = ocr_pkg::ones_add(sum_r, {held_r, sum_byte});
        end
      end
    end
    len_upd = take ? pos_r + POS_W'(1) : pos_r;
  end

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    held_nxt   = held_r;
    ver_nxt    = ver_r;
    type_nxt   = type_r;
    auth_nxt   = auth_r;
    rid_nxt    = rid_r;
    area_nxt   = area_r;
    src_nxt    = src_r;
    body_a_nxt = body_a_r;
    body_b_nxt = body_b_r;
    if (fire) begin
      if (in_last_byte) begin
        pos_nxt    = '0;
        sum_nxt    = '0;
        held_nxt   = '0;
        ver_nxt    = '0;
        type_nxt   = '0;
        auth_nxt   = '0;
        rid_nxt    = '0;
        area_nxt   = '0;
        src_nxt    = '0;
        body_a_nxt = '0;
        body_b_nxt = '0;
      end else begin
        pos_nxt    = len_upd;
        sum_nxt    = sum_upd;
        held_nxt   = held_upd;
        ver_nxt    = ver_upd;
        type_nxt   = type_upd;
        auth_nxt   = auth_upd;
        rid_nxt    = rid_upd;
        area_nxt   = area_upd;
        src_nxt    = src_upd;
        body_a_nxt = body_a_upd;
        body_b_nxt = body_b_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      held_r   <= '0;
      ver_r    <= '0;
      type_r   <= '0;
      auth_r   <= '0;
      rid_r    <= '0;
      area_r   <= '0;
      src_r    <= '0;
      body_a_r <= '0;
      body_b_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      held_r   <= held_nxt;
      ver_r    <= ver_nxt;
      type_r   <= type_nxt;
      auth_r   <= auth_nxt;
      rid_r    <= rid_nxt;
      area_r   <= area_nxt;
      src_r    <= src_nxt;
      body_a_r <= body_a_nxt;
      body_b_r <= body_b_nxt;
    end
  end

  always_comb begin
    push_rec.len          = ocr_pkg::LEN_W'(len_upd);
    push_rec.sum          = sum_upd;
    push_rec.held         = held_upd;
    push_rec.ver_ok       = ver_upd == ocr_pkg::OSPF_VERSION;
    push_rec.area_ok      = area_upd == area_id;
    push_rec.auth_ok      = auth_upd == 8'h00;
    push_rec.mask_ok      = body_a_upd == port_netmask;
    push_rec.intvl_ok     = body_b_upd[31:16] == port_hello_interval;
    push_rec.pkt_type     = type_upd;
    push_rec.router_id    = rid_upd;
    push_rec.source_ip    = src_upd;
    push_rec.lsu_seq      = body_a_upd[31:16];
    push_rec.advert_count = body_b_upd;
  end

  `OCR_ASSERT_CLK(a_pos_saturates, pos_r <= POS_W'(MAX_FRAME_BYTES), "byte position past maximum")

endmodule

// ===== rtl/core/ocr_queue.sv =====
// ----------------------------------------------------------------------------
// ocr_queue
// short frame-summary queue between front end and judge
// ----------------------------------------------------------------------------
module ocr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ocr_pkg::frame_rec_t push_rec,
  input  logic                pop,
  output ocr_pkg::frame_rec_t head_rec,
  output ocr_pkg::q_stat_t    q_stat
);

  `include "assert_macros.svh"

  localparam int DEPTH = ocr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ocr_pkg::frame_rec_t entry_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  assign head_rec     = entry_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == CNT_W'(DEPTH);
  assign q_stat.empty = cnt_r == '0;

  `OCR_ASSERT_CLK(a_q_no_overflow, push |-> !q_stat.full, "push into full queue")
  `OCR_ASSERT_CLK(a_q_no_underflow, pop |-> !q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/core/ocr_judge.sv =====
// ----------------------------------------------------------------------------
// ocr_judge
// back end: checksum tail fold, ordered checks, result register
// ----------------------------------------------------------------------------
module ocr_judge (
  input  logic                clk,
  input  logic                rst_n,
  input  ocr_pkg::frame_rec_t head_rec,
  input  ocr_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_verdict,
  output logic [7:0]          out_packet_type,
  output logic [31:0]         out_router_id,
  output logic [31:0]         out_source_ip,
  output logic [15:0]         out_lsu_sequence,
  output logic [31:0]         out_advert_count
);

  `include "assert_macros.svh"

  localparam int NEED_W = 32 + 4;

  logic              out_valid_r, out_valid_nxt;
  ocr_pkg::verdict_t verdict_r, verdict_nxt;
  logic [7:0]        type_r;
  logic [31:0]       rid_r, src_r, count_r;
  logic [15:0]       seq_r;

  logic              tail;
  logic [15:0]       sum_fin;
  logic [NEED_W-1:0] need;
  logic              is_hello, is_lsu;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    // odd ospf length: last high byte padded with a zero low byte
    tail     = head_rec.len > ocr_pkg::OSPF_START && head_rec.len[0];
    sum_fin  = tail ? ocr_pkg::ones_add(head_rec.sum, {head_rec.held, 8'h00}) : head_rec.sum;
    // 66 + 12 * count as two shifted copies
    need     = NEED_W'(ocr_pkg::HELLO_END) + {1'b0, head_rec.advert_count, 3'b000}
             + {2'b00, head_rec.advert_count, 2'b00};
    is_hello = head_rec.pkt_type == ocr_pkg::PKT_HELLO;
    is_lsu   = head_rec.pkt_type == ocr_pkg::PKT_LSU;

    if (head_rec.len < ocr_pkg::BODY_START) begin
      verdict_nxt = ocr_pkg::VERDICT_SHORT;
    end else if (!head_rec.ver_ok) begin
      verdict_nxt = ocr_pkg::VERDICT_VERSION;
    end else if (sum_fin != ocr_pkg::SUM_GOOD) begin
      verdict_nxt = ocr_pkg::VERDICT_CHECKSUM;
    end else if (!head_rec.area_ok) begin
      verdict_nxt = ocr_pkg::VERDICT_AREA;
    end else if (!head_rec.auth_ok) begin
      verdict_nxt = ocr_pkg::VERDICT_AUTH;
    end else if (is_hello) begin
      if (head_rec.len < ocr_pkg::HELLO_END) begin
        verdict_nxt = ocr_pkg::VERDICT_SHORT;
      end else if (!head_rec.mask_ok) begin
        verdict_nxt = ocr_pkg::VERDICT_NETMASK;
      end else if (!head_rec.intvl_ok) begin
        verdict_nxt = ocr_pkg::VERDICT_INTERVAL;
      end else begin
        verdict_nxt = ocr_pkg::VERDICT_OK;
      end
    end else if (is_lsu && NEED_W'(head_rec.len) < need) begin
      verdict_nxt = ocr_pkg::VERDICT_LSU_SHORT;
    end else begin
      verdict_nxt = ocr_pkg::VERDICT_OK;
    end

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r <= verdict_nxt;
      type_r    <= head_rec.pkt_type;
      rid_r     <= head_rec.router_id;
      src_r     <= head_rec.source_ip;
      seq_r     <= is_lsu ? head_rec.lsu_seq : 16'd0;
      count_r   <= is_lsu ? head_rec.advert_count : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_packet_type  = type_r;
  assign out_router_id    = rid_r;
  assign out_source_ip    = src_r;
  assign out_lsu_sequence = seq_r;
  assign out_advert_count = count_r;

  `OCR_ASSERT_ALL(a_no_result_after_reset, !rst_n |=> !out_valid_r, "result valid after reset")
  `OCR_ASSERT_CLK(a_pop_loads_result, pop |=> out_valid_r, "popped frame not presented")

endmodule

// ===== rtl/core/ospf_packet_receive_checker.sv =====
// ----------------------------------------------------------------------------
// ospf_packet_receive_checker
// Takes an Ethernet/IPv4/OSPF frame one byte per cycle from the first
// Ethernet header byte and gives one verdict per frame, with type, router id,
// source address, LSU sequence and advertisement count. Bytes stream in at
// one per cycle; in_ready drops only on a last byte while the two-entry frame
// queue is full. A verdict passes through the queue, then the result register;
// one verdict per cycle can leave while out_ready is high, so single-byte
// frames back to back also run at full rate. Bytes past MAX_FRAME_BYTES are
// ignored and the length stops there. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ospf_packet_receive_checker #(
  parameter int MAX_FRAME_BYTES = ocr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_verdict,
  output logic [7:0]                    out_packet_type,
  output logic [31:0]                   out_router_id,
  output logic [31:0]                   out_source_ip,
  output logic [15:0]                   out_lsu_sequence,
  output logic [31:0]                   out_advert_count,
  input  logic                          cfg_we,
  input  logic [ocr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ocr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [31:0]         area_id_r, area_id_nxt;
  logic [31:0]         netmask_r, netmask_nxt;
  logic [15:0]         hello_intvl_r, hello_intvl_nxt;

  logic                push, pop;
  ocr_pkg::frame_rec_t push_rec, head_rec;
  ocr_pkg::q_stat_t    q_stat;

  always_comb begin
    area_id_nxt     = area_id_r;
    netmask_nxt     = netmask_r;
    hello_intvl_nxt = hello_intvl_r;
    if (cfg_we) begin
      case (cfg_index)
        ocr_pkg::CFG_AREA_ID: begin
          area_id_nxt = cfg_data[31:0];
        end
        ocr_pkg::CFG_PORT_NETMASK: begin
          netmask_nxt = cfg_data[31:0];
        end
        ocr_pkg::CFG_PORT_HELLO_INTERVAL: begin
          hello_intvl_nxt = cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_id_r     <= '0;
      netmask_r     <= '0;
      hello_intvl_r <= '0;
    end else begin
      area_id_r     <= area_id_nxt;
      netmask_r     <= netmask_nxt;
      hello_intvl_r <= hello_intvl_nxt;
    end
  end

  ocr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .area_id             (area_id_r),
    .port_netmask        (netmask_r),
    .port_hello_interval (hello_intvl_r),
    .q_stat              (q_stat),
    .push                (push),
    .push_rec            (push_rec)
  );

  ocr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  ocr_judge u_judge (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_rec         (head_rec),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_packet_type  (out_packet_type),
    .out_router_id    (out_router_id),
    .out_source_ip    (out_source_ip),
    .out_lsu_sequence (out_lsu_sequence),
    .out_advert_count (out_advert_count)
  );

endmodule

// ===== tb/ospf_packet_receive_checker_tb.sv =====
// ----------------------------------------------------------------------------
// ospf_packet_receive_checker_tb
// Streams Ethernet/IPv4/OSPF frames into the receive checker one byte per
// word and checks every result against a cycle-free predictor of the frame
// checks; hand-built frames from a table, most with the expected verdict taken
// from the table, cover each verdict and the length corner cases. Random frames
// follow under three config settings and three stall mixes: Hello, LSU and
// other frames, some with one fault, some truncated, and plain noise.
// ----------------------------------------------------------------------------
module ospf_packet_receive_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ocr_pkg::*;

  localparam int FRAME_CAP   = 2048;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    FLT_NONE, FLT_NOISE, FLT_FILL, FLT_VERSION, FLT_SUM, FLT_AREA, FLT_AUTH,
    FLT_MASK, FLT_INTVL
  } frame_fault_t;

  typedef struct {
    logic [7:0]   ptype;
    int           nbytes;
    logic [31:0]  count;
    frame_fault_t fault;
    bit           typed;
    verdict_t     verdict;
  } frame_row_t;

  typedef struct {
    verdict_t    verdict;
    logic [7:0]  ptype;
    logic [31:0] router_id;
    logic [31:0] source_ip;
    logic [15:0] lsu_seq;
    logic [31:0] advert_count;
  } ospf_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_verdict;
  logic [7:0]  out_packet_type;
  logic [31:0] out_router_id;
  logic [31:0] out_source_ip;
  logic [15:0] out_lsu_sequence;
  logic [31:0] out_advert_count;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ospf_packet_receive_checker #(.MAX_FRAME_BYTES(FRAME_CAP)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_packet_type  (out_packet_type),
    .out_router_id    (out_router_id),
    .out_source_ip    (out_source_ip),
    .out_lsu_sequence (out_lsu_sequence),
    .out_advert_count (out_advert_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the config registers
  logic [31:0] area_cfg;
  logic [31:0] netmask_cfg;
  logic [15:0] interval_cfg;

  // predictor per-frame state
  int          rx_pos;
  logic [16:0] rx_sum;
  logic [7:0]  rx_held;
  logic [7:0]  rx_ver;
  logic [7:0]  rx_type;
  logic [7:0]  rx_auth;
  logic [31:0] rx_rid;
  logic [31:0] rx_area;
  logic [31:0] rx_src;
  logic [31:0] rx_body_a;
  logic [31:0] rx_body_b;

  ospf_result_t pending_verdicts[$];
  logic [7:0]   frame_bytes[$];

  bit       row_typed;
  verdict_t row_verdict;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       mismatch_count;
  int       results_checked;
  int       bytes_sent;
  int       frames_sent;
  int       cycle_count;
  int       verdict_hits[9];

  frame_row_t directed_rows[22] = '{
    '{8'h00,     1,    32'd0,         FLT_NOISE,   1'b1, VERDICT_SHORT},
    '{8'h00,     57,   32'd0,         FLT_NOISE,   1'b1, VERDICT_SHORT},
    '{PKT_HELLO, 35,   32'd0,         FLT_NONE,    1'b1, VERDICT_SHORT},
    '{PKT_HELLO, 66,   32'd0,         FLT_NONE,    1'b1, VERDICT_OK},
    '{PKT_HELLO, 60,   32'd0,         FLT_NONE,    1'b1, VERDICT_SHORT},
    '{PKT_HELLO, 66,   32'd0,         FLT_VERSION, 1'b1, VERDICT_VERSION},
    '{PKT_HELLO, 70,   32'd0,         FLT_SUM,     1'b1, VERDICT_CHECKSUM},
    '{PKT_HELLO, 66,   32'd0,         FLT_AREA,    1'b1, VERDICT_AREA},
    '{PKT_HELLO, 66,   32'd0,         FLT_AUTH,    1'b1, VERDICT_AUTH},
    '{PKT_LSU,   66,   32'd1,         FLT_AUTH,    1'b1, VERDICT_AUTH},
    '{PKT_HELLO, 66,   32'd0,         FLT_MASK,    1'b1, VERDICT_NETMASK},
    '{PKT_HELLO, 67,   32'd0,         FLT_INTVL,   1'b1, VERDICT_INTERVAL},
    '{PKT_LSU,   66,   32'd0,         FLT_NONE,    1'b1, VERDICT_OK},
    '{PKT_LSU,   102,  32'd3,         FLT_NONE,    1'b1, VERDICT_OK},
    '{PKT_LSU,   101,  32'd3,         FLT_NONE,    1'b1, VERDICT_LSU_SHORT},
    '{PKT_LSU,   70,   32'hFFFF_FFFF, FLT_NONE,    1'b1, VERDICT_LSU_SHORT},
    '{PKT_LSU,   79,   32'd1,         FLT_NONE,    1'b1, VERDICT_OK},
    '{8'h02,     58,   32'd0,         FLT_NONE,    1'b1, VERDICT_OK},
    '{8'h05,     2100, 32'd0,         FLT_NONE,    1'b1, VERDICT_OK},
    '{8'hFF,     66,   32'd0,         FLT_FILL,    1'b1, VERDICT_VERSION},
    '{8'h00,     66,   32'd0,         FLT_FILL,    1'b1, VERDICT_VERSION},
    '{8'h00,     200,  32'd0,         FLT_NOISE,   1'b0, VERDICT_OK}
  };

  function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = acc + {1'b0, w};
    if (s[16]) s = {1'b0, s[15:0]} + 17'd1;
    return s;
  endfunction

  function automatic void clear_frame_state();
    rx_pos = 0;
    rx_sum = '0;
    rx_held = '0;
    rx_ver = '0;
    rx_type = '0;
    rx_auth = '0;
    rx_rid = '0;
    rx_area = '0;
    rx_src = '0;
    rx_body_a = '0;
    rx_body_b = '0;
  endfunction

  // runs one accepted word through the predictor, queues a verdict on the last
  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0]   cb;
    int           len;
    logic [63:0]  need;
    ospf_result_t r;
    if (rx_pos < FRAME_CAP) begin
      if (rx_pos >= POS_SRC_FIRST && rx_pos <= POS_SRC_LAST) rx_src = {rx_src[23:0], b};
      if (rx_pos == OSPF_START) rx_ver = b;
      if (rx_pos == POS_TYPE) rx_type = b;
      if (rx_pos >= POS_RID_FIRST && rx_pos <= POS_RID_LAST) rx_rid = {rx_rid[23:0], b};
      if (rx_pos >= POS_AREA_FIRST && rx_pos <= POS_AREA_LAST) rx_area = {rx_area[23:0], b};
      if (rx_pos == POS_AUTYPE_HI || rx_pos == POS_AUTYPE_LO) rx_auth |= b;
      if (rx_pos >= BODY_START && rx_pos <= POS_BODY_A_LAST) rx_body_a = {rx_body_a[23:0], b};
      if (rx_pos >= POS_BODY_B_FIRST && rx_pos <= POS_BODY_B_LAST)
        rx_body_b = {rx_body_b[23:0], b};
      if (rx_pos >= OSPF_START) begin
        cb = (rx_pos >= AUTH_DATA_FIRST && rx_pos <= AUTH_DATA_LAST) ? 8'h00 : b;
        if (((rx_pos - OSPF_START) & 1) == 0) rx_held = cb;
        else rx_sum = fold_add(rx_sum, {rx_held, cb});
      end
      rx_pos++;
    end
    if (!last) return;

    len = rx_pos;
    // odd ospf length: pad the held byte with a zero low byte
    if (len > OSPF_START && ((len - OSPF_START) & 1) != 0) rx_sum = fold_add(rx_sum, {rx_held, 8'h00});
    need = 64'(HELLO_END) + 64'(AD_BYTES) * 64'(rx_body_b);

    if (len < BODY_START) r.verdict = VERDICT_SHORT;
    else if (rx_ver != OSPF_VERSION) r.verdict = VERDICT_VERSION;
    else if (rx_sum != {1'b0, SUM_GOOD}) r.verdict = VERDICT_CHECKSUM;
    else if (rx_area != area_cfg) r.verdict = VERDICT_AREA;
    else if (rx_auth != 8'h00) r.verdict = VERDICT_AUTH;
    else if (rx_type == PKT_HELLO) begin
      if (len < HELLO_END) r.verdict = VERDICT_SHORT;
      else if (rx_body_a != netmask_cfg) r.verdict = VERDICT_NETMASK;
      else if (rx_body_b[31:16] != interval_cfg) r.verdict = VERDICT_INTERVAL;
      else r.verdict = VERDICT_OK;
    end else if (rx_type == PKT_LSU && 64'(len) < need) r.verdict = VERDICT_LSU_SHORT;
    else r.verdict = VERDICT_OK;

    if (row_typed) r.verdict = row_verdict;
    r.ptype = rx_type;
    r.router_id = rx_rid;
    r.source_ip = rx_src;
    r.lsu_seq = (rx_type == PKT_LSU) ? rx_body_a[31:16] : 16'h0000;
    r.advert_count = (rx_type == PKT_LSU) ? rx_body_b : 32'h0;
    pending_verdicts.push_back(r);
    clear_frame_state();
  endfunction

  function automatic void compare_verdict();
    ospf_result_t want;
    results_checked++;
    if (pending_verdicts.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected verdict %0d type %02h rid %08h src %08h", out_verdict,
                 out_packet_type, out_router_id, out_source_ip);
      return;
    end
    want = pending_verdicts.pop_front();
    if (out_verdict !== want.verdict || out_packet_type !== want.ptype ||
        out_router_id !== want.router_id || out_source_ip !== want.source_ip ||
        out_lsu_sequence !== want.lsu_seq || out_advert_count !== want.advert_count) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch exp: verdict %0d type %02h rid %08h src %08h seq %04h cnt %08h",
                 want.verdict, want.ptype, want.router_id, want.source_ip, want.lsu_seq,
                 want.advert_count);
        $display("         got: verdict %0d type %02h rid %08h src %08h seq %04h cnt %08h",
                 out_verdict, out_packet_type, out_router_id, out_source_ip,
                 out_lsu_sequence, out_advert_count);
      end
    end else begin
      verdict_hits[int'(want.verdict)]++;
    end
  endfunction

  // inputs only move at the rising edge, so the falling edge sees stable handshakes
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) compare_verdict();
      if (in_valid && in_ready) track_frame_byte(in_data_byte, in_last_byte);
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void put_byte(input int pos, input logic [7:0] v);
    if (pos < frame_bytes.size()) frame_bytes[pos] = v;
  endfunction

  function automatic void put_word(input int pos, input logic [31:0] v);
    put_byte(pos, v[31:24]);
    put_byte(pos + 1, v[23:16]);
    put_byte(pos + 2, v[15:8]);
    put_byte(pos + 3, v[7:0]);
  endfunction

  function automatic void make_frame(input frame_row_t r);
    int          i;
    int          lim;
    int          sel;
    logic [16:0] acc;
    logic [15:0] ivl;
    frame_bytes.delete();
    for (i = 0; i < r.nbytes; i++)
      frame_bytes.push_back((r.fault == FLT_FILL) ? r.ptype : 8'($urandom));
    if (r.fault == FLT_NOISE || r.fault == FLT_FILL) return;

    put_byte(OSPF_START, (r.fault == FLT_VERSION) ? 8'(OSPF_VERSION + 1 + $urandom_range(250))
                                                  : OSPF_VERSION);
    put_byte(POS_TYPE, r.ptype);
    put_byte(36, 8'((r.nbytes - OSPF_START) >> 8));
    put_byte(37, 8'(r.nbytes - OSPF_START));
    put_word(POS_AREA_FIRST, area_cfg ^ ((r.fault == FLT_AREA) ? (32'h1 << $urandom_range(31))
                                                              : 32'h0));
    put_byte(46, 8'h00);
    put_byte(47, 8'h00);
    put_byte(POS_AUTYPE_HI, 8'h00);
    put_byte(POS_AUTYPE_LO, 8'h00);
    if (r.fault == FLT_AUTH) put_byte(POS_AUTYPE_HI + r.count[0], 8'($urandom_range(1, 255)));
    if (r.ptype == PKT_HELLO) begin
      put_word(BODY_START, netmask_cfg ^ ((r.fault == FLT_MASK) ? (32'h1 << $urandom_range(31))
                                                               : 32'h0));
      ivl = interval_cfg ^ ((r.fault == FLT_INTVL) ? (16'h1 << $urandom_range(15)) : 16'h0);
      put_byte(POS_BODY_B_FIRST, ivl[15:8]);
      put_byte(POS_BODY_B_FIRST + 1, ivl[7:0]);
    end
    if (r.ptype == PKT_LSU) put_word(POS_BODY_B_FIRST, r.count);

    // checksum so the folded sum comes out all ones; auth data does not count
    lim = (r.nbytes < FRAME_CAP) ? r.nbytes : FRAME_CAP;
    acc = '0;
    for (i = OSPF_START; i < lim; i += 2)
      if (i < AUTH_DATA_FIRST || i > AUTH_DATA_LAST)
        acc = fold_add(acc, {frame_bytes[i], (i + 1 < lim) ? frame_bytes[i + 1] : 8'h00});
    put_byte(46, ~acc[15:8]);
    put_byte(47, ~acc[7:0]);
    if (r.fault == FLT_SUM) begin
      // hit the length or checksum field so no other check trips first
      sel = $urandom_range(3);
      i = (sel < 2) ? 36 + sel : 44 + sel;
      put_byte(i, frame_bytes[i] ^ 8'(1 << $urandom_range(7)));
    end
  endfunction

  function automatic frame_row_t pick_random_row();
    frame_row_t r;
    int         roll;
    r.typed = 1'b0;
    r.verdict = VERDICT_OK;
    r.count = $urandom;
    r.fault = FLT_NONE;
    r.ptype = 8'h00;
    roll = $urandom_range(99);
    if (roll < 20) begin
      r.fault = FLT_NOISE;
      r.nbytes = (roll < 5) ? $urandom_range(1, 4) : $urandom_range(5, 90);
      return r;
    end
    roll = $urandom_range(99);
    r.ptype = (roll < 40) ? PKT_HELLO : (roll < 80) ? PKT_LSU : 8'($urandom);
    if (r.ptype == PKT_HELLO) r.nbytes = HELLO_END + $urandom_range(0, 6);
    else if (r.ptype == PKT_LSU) begin
      r.count = $urandom_range(0, 3);
      r.nbytes = HELLO_END + AD_BYTES * r.count + $urandom_range(0, 3);
      roll = $urandom_range(9);
      if (roll == 0) r.count = $urandom;
      else if (roll == 1) r.nbytes -= $urandom_range(1, 12);
    end else r.nbytes = BODY_START + $urandom_range(0, 10);
    roll = $urandom_range(99);
    if (roll >= 64) r.fault = frame_fault_t'(int'(FLT_VERSION) + (roll - 64) % 6);
    else if (roll >= 56) r.nbytes = $urandom_range(35, 65);
    return r;
  endfunction

  // call right after a rising edge; returns right after the edge taking the last word
  task automatic send_frame();
    int k;
    bit taken;
    for (k = 0; k < frame_bytes.size(); k++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= frame_bytes[k];
      in_last_byte <= (k == frame_bytes.size() - 1);
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = in_ready;
        @(posedge clk);
      end
    end
    bytes_sent += frame_bytes.size();
    frames_sent++;
  endtask

  task automatic load_config(input logic [31:0] area, input logic [31:0] mask,
                             input logic [15:0] ivl);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AREA_ID;
    cfg_data <= area;
    @(posedge clk);
    cfg_index <= CFG_PORT_NETMASK;
    cfg_data <= mask;
    @(posedge clk);
    cfg_index <= CFG_PORT_HELLO_INTERVAL;
    cfg_data <= {16'h0000, ivl};
    @(posedge clk);
    cfg_we <= 1'b0;
    area_cfg = area;
    netmask_cfg = mask;
    interval_cfg = ivl;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    frame_row_t r;
    int         ph;
    int         phase_bytes;
    int         phase_frames;
    area_cfg = '0;
    netmask_cfg = '0;
    interval_cfg = '0;
    clear_frame_state();
    row_typed = 1'b0;
    row_verdict = VERDICT_OK;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatch_count = 0;
    results_checked = 0;
    bytes_sent = 0;
    frames_sent = 0;
    cycle_count = 0;
    foreach (verdict_hits[v]) verdict_hits[v] = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_config(32'h0A0B_0C0D, 32'hFFFF_FF00, 16'd10);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      row_typed = r.typed;
      row_verdict = r.verdict;
      make_frame(r);
      send_frame();
    end
    row_typed = 1'b0;
    settle();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 78;
          load_config($urandom, $urandom, 16'($urandom));
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 16;
          load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          load_config(32'h0, 32'h0, 16'h0);
        end
      endcase
      phase_bytes = bytes_sent;
      phase_frames = frames_sent;
      while (bytes_sent - phase_bytes < 517 || frames_sent - phase_frames < 20) begin
        make_frame(pick_random_row());
        send_frame();
      end
      settle();
    end

    mismatch_count += pending_verdicts.size();
    $display("%0d frames (%0d bytes, one past the length cap) under four register settings",
             frames_sent, bytes_sent);
    $display("verdicts ok/short/ver/sum/area/auth/mask/intvl/lsu: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3], verdict_hits[4],
             verdict_hits[5], verdict_hits[6], verdict_hits[7], verdict_hits[8]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d of %0d verdicts wrong or missing", mismatch_count, results_checked);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ocr_pkg.sv
rtl/core/ocr_front.sv
rtl/core/ocr_queue.sv
rtl/core/ocr_judge.sv
rtl/core/ospf_packet_receive_checker.sv
tb/ospf_packet_receive_checker_tb.sv
